// ===== rtl/core/stsf_pkg.sv =====
// Package for the speaker tone sample FIFO.
// Holds the queue geometry, the arithmetic widths, the level codes and the sequencer states.
// No dependencies.
package stsf_pkg;

   localparam int QUEUE_DEPTH = 8192;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = IDX_W + 1;
   localparam int CNT_W       = 12;
   localparam int SR_W        = 18;
   localparam int RATE_W      = 16;
   localparam int DIV_W       = 26;
   localparam int DIV_CNT_W   = 5;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 32;

   typedef logic [IDX_W-1:0]     idx_type;
   typedef logic [FILL_W-1:0]    fill_type;
   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [SR_W-1:0]      sr_type;
   typedef logic [RATE_W-1:0]    rate_type;
   typedef logic [DIV_W-1:0]     div_type;
   typedef logic [DIV_CNT_W-1:0] div_cnt_type;
   typedef logic [1:0]           level_type;

   localparam fill_type    QUEUE_SIZE   = fill_type'(QUEUE_DEPTH);
   localparam cnt_type     BURST_LIMIT  = 12'd2048;
   localparam div_type     CPU_CLOCK_HZ = 26'd4770000;
   localparam sr_type      SR_RESET     = 18'd44100;
   localparam div_cnt_type DIV_STEPS    = 5'd26;

   localparam level_type LEVEL_NONE = 2'b00;
   localparam level_type LEVEL_HIGH = 2'b01;
   localparam level_type LEVEL_LOW  = 2'b11;

   localparam logic KIND_PLAY   = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_POP      = 7'b0000010,
      ST_DIV_RATE = 7'b0000100,
      ST_DIV_LEN  = 7'b0001000,
      ST_DIV_STEP = 7'b0010000,
      ST_FILL     = 7'b0100000,
      ST_REPLY    = 7'b1000000
   } state_type;

endpackage

// ===== rtl/core/stsf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Standalone; used for the sample ring buffer.
module stsf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/speaker_tone_sample_fifo.sv =====
// Square-wave tone generator feeding a ring FIFO of one-bit samples.
// Depends on stsf_pkg and stsf_ram.
//
//   channel | direction | tdata (low bit up)                              | tuser
//   req     | in        | tone_delay[7:0], flip_count[7:0]                | kind
//   rsp     | out       | sample_level[1:0], queued_count[11:0],          | none
//           |           | queue_fill[13:0], four zero bits                |
//   csr     | in        | csr_wr_data = out_rate[17:0], csr_wr_en         | none
//
// A sample item passes through the pop and reply states (only the reply state when the FIFO is empty).
// A play item runs up to three divisions on a shared one-bit-per-cycle divider, then the RAM
// write port takes one sample a cycle.
// One item is in work at a time; req_tready is high only when the sequencer is idle.
// A finished result waits in the output register while rsp_tready is low.
// Reset clears the indexes, the fill count and the control state; the store is not cleared.
module speaker_tone_sample_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [stsf_pkg::REQ_DATA_W-1:0] req_tdata,   // tone_delay[7:0], flip_count[15:8]
   input  logic                            req_tuser,   // kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // sample_level[1:0], queued_count[13:2], queue_fill[27:14]
   output logic [stsf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [17:0]                     csr_wr_data  // out_rate
);

   stsf_pkg::state_type   state_ff, state_in;
   stsf_pkg::sr_type      out_rate_ff;
   stsf_pkg::idx_type     rd_idx_ff, rd_idx_in;
   stsf_pkg::idx_type     wr_idx_ff, wr_idx_in;
   stsf_pkg::fill_type    fill_ff, fill_in;

   stsf_pkg::sr_type      div_rem_ff, div_rem_in;
   stsf_pkg::div_type     div_quo_ff, div_quo_in;
   stsf_pkg::sr_type      div_den_ff, div_den_in;
   stsf_pkg::div_cnt_type div_cnt_ff, div_cnt_in;

   logic [7:0]            cl_ff, cl_in;
   stsf_pkg::rate_type    rate_ff, rate_in;
   stsf_pkg::cnt_type     len_ff, len_in;
   stsf_pkg::cnt_type     left_ff, left_in;
   stsf_pkg::sr_type      acc_ff, acc_in;
   stsf_pkg::sr_type      step_rem_ff, step_rem_in;
   logic                  step_odd_ff, step_odd_in;
   logic                  high_ff, high_in;
   stsf_pkg::level_type   lvl_ff, lvl_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [stsf_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  req_xfer;
   logic [13:0]           period;
   logic [18:0]           div_trial;
   logic [18:0]           div_diff;
   logic                  div_ge;
   logic                  div_done;
   stsf_pkg::cnt_type     len_cap;
   stsf_pkg::fill_type    space;
   stsf_pkg::cnt_type     len_fit;
   logic [18:0]           acc_sum;
   logic                  acc_carry;
   logic                  ram_rd_data;

   stsf_ram #(
      .WIDTH(1),
      .DEPTH(stsf_pkg::QUEUE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (state_ff == stsf_pkg::ST_FILL),
      .wr_addr(wr_idx_ff),
      .wr_data(high_ff),
      .rd_addr(rd_idx_ff),
      .rd_data(ram_rd_data)
   );

   assign req_tready = (state_ff == stsf_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Loop period of the tone, reckoned from tone_delay.
   assign period = ((14'(req_tdata[7:0]) * 14'd19) + 14'd56) << 1;

   // One restoring division step: remainder stays below the divisor.
   assign div_trial = {div_rem_ff, div_quo_ff[stsf_pkg::DIV_W-1]};
   assign div_diff  = div_trial - {1'b0, div_den_ff};
   assign div_ge    = (div_trial >= {1'b0, div_den_ff});
   assign div_done  = (div_cnt_ff == stsf_pkg::DIV_STEPS);

   assign len_cap = (div_quo_ff > stsf_pkg::div_type'(stsf_pkg::BURST_LIMIT)) ?
                    stsf_pkg::BURST_LIMIT : div_quo_ff[stsf_pkg::CNT_W-1:0];
   assign space   = stsf_pkg::QUEUE_SIZE - fill_ff;
   assign len_fit = (stsf_pkg::fill_type'(len_cap) > space) ?
                    space[stsf_pkg::CNT_W-1:0] : len_cap;

   // The accumulator gains rate = q*out_rate + r per sample, so it wraps
   // q times plus once more when acc + r reaches the output rate.
   assign acc_sum   = {1'b0, acc_ff} + {1'b0, step_rem_ff};
   assign acc_carry = (acc_sum >= {1'b0, out_rate_ff});

   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      fill_in      = fill_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_den_in   = div_den_ff;
      div_cnt_in   = div_cnt_ff;
      cl_in        = cl_ff;
      rate_in      = rate_ff;
      len_in       = len_ff;
      left_in      = left_ff;
      acc_in       = acc_ff;
      step_rem_in  = step_rem_ff;
      step_odd_in  = step_odd_ff;
      high_in      = high_ff;
      lvl_in       = lvl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if ((state_ff == stsf_pkg::ST_DIV_RATE || state_ff == stsf_pkg::ST_DIV_LEN ||
           state_ff == stsf_pkg::ST_DIV_STEP) && !div_done) begin
         div_rem_in = div_ge ? div_diff[stsf_pkg::SR_W-1:0] : div_trial[stsf_pkg::SR_W-1:0];
         div_quo_in = {div_quo_ff[stsf_pkg::DIV_W-2:0], div_ge};
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      unique case (state_ff)
         stsf_pkg::ST_IDLE: begin
            if (req_xfer) begin
               lvl_in = stsf_pkg::LEVEL_NONE;
               len_in = '0;
               cl_in  = req_tdata[15:8];
               if (req_tuser == stsf_pkg::KIND_SAMPLE) begin
                  state_in = (fill_ff != '0) ? stsf_pkg::ST_POP : stsf_pkg::ST_REPLY;
               end else begin
                  div_rem_in = '0;
                  div_quo_in = stsf_pkg::CPU_CLOCK_HZ;
                  div_den_in = stsf_pkg::sr_type'(period);
                  div_cnt_in = '0;
                  state_in   = stsf_pkg::ST_DIV_RATE;
               end
            end
         end
         stsf_pkg::ST_POP: begin
            lvl_in    = ram_rd_data ? stsf_pkg::LEVEL_HIGH : stsf_pkg::LEVEL_LOW;
            rd_idx_in = rd_idx_ff + 1'b1;
            fill_in   = fill_ff - 1'b1;
            state_in  = stsf_pkg::ST_REPLY;
         end
         stsf_pkg::ST_DIV_RATE: begin
            if (div_done) begin
               rate_in    = div_quo_ff[stsf_pkg::RATE_W-1:0];
               div_rem_in = '0;
               div_quo_in = stsf_pkg::div_type'(out_rate_ff) * stsf_pkg::div_type'(cl_ff);
               div_den_in = stsf_pkg::sr_type'(div_quo_ff[stsf_pkg::RATE_W-1:0]);
               div_cnt_in = '0;
               state_in   = stsf_pkg::ST_DIV_LEN;
            end
         end
         stsf_pkg::ST_DIV_LEN: begin
            if (div_done) begin
               len_in  = len_fit;
               left_in = len_fit;
               if (len_fit == '0) begin
                  state_in = stsf_pkg::ST_REPLY;
               end else begin
                  div_rem_in = '0;
                  div_quo_in = stsf_pkg::div_type'(rate_ff);
                  div_den_in = out_rate_ff;
                  div_cnt_in = '0;
                  state_in   = stsf_pkg::ST_DIV_STEP;
               end
            end
         end
         stsf_pkg::ST_DIV_STEP: begin
            if (div_done) begin
               step_odd_in = div_quo_ff[0];
               step_rem_in = div_rem_ff;
               acc_in      = '0;
               high_in     = 1'b0;
               state_in    = stsf_pkg::ST_FILL;
            end
         end
         stsf_pkg::ST_FILL: begin
            wr_idx_in = wr_idx_ff + 1'b1;
            acc_in    = acc_carry ? stsf_pkg::sr_type'(acc_sum - {1'b0, out_rate_ff}) :
                        acc_sum[stsf_pkg::SR_W-1:0];
            high_in   = high_ff ^ step_odd_ff ^ acc_carry;
            left_in   = left_ff - 1'b1;
            if (left_ff == stsf_pkg::cnt_type'(1)) begin
               fill_in  = fill_ff + stsf_pkg::fill_type'(len_ff);
               state_in = stsf_pkg::ST_REPLY;
            end
         end
         stsf_pkg::ST_REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, fill_ff, len_ff, lvl_ff};
               state_in     = stsf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stsf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stsf_pkg::ST_IDLE;
         out_rate_ff  <= stsf_pkg::SR_RESET;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         fill_ff      <= '0;
         div_cnt_ff   <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         fill_ff      <= fill_in;
         div_cnt_ff   <= div_cnt_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            out_rate_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_den_ff  <= div_den_in;
      cl_ff       <= cl_in;
      rate_ff     <= rate_in;
      len_ff      <= len_in;
      acc_ff      <= acc_in;
      step_rem_ff <= step_rem_in;
      step_odd_ff <= step_odd_in;
      high_ff     <= high_in;
      lvl_ff      <= lvl_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/core/stsf_checker.sv =====
// Port-level checks for the speaker tone sample FIFO, bound to the top level.
// Depends on speaker_tone_sample_fifo's port names only.
module stsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A stalled result stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // The block works on one item at a time.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in work");

   // A popped sample never comes with pushed samples.
   a_pop_or_push: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != 2'b00 |-> rsp_tdata[13:2] == 12'd0)
      else $error("sample result reports pushed samples");

   // A burst never exceeds its limit and the FIFO never overfills.
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[13:2] <= 12'd2048 && rsp_tdata[27:14] <= 14'd8192)
      else $error("count out of range");

endmodule

bind speaker_tone_sample_fifo stsf_checker u_stsf_checker (.*);

// ===== dv/speaker_tone_sample_fifo_tb.sv =====
// Self-checking testbench for speaker_tone_sample_fifo: tone bursts, sample pops and rate writes.
// Predicts every reply with its own tone generator and FIFO model, then compares each field.
// Depends on stsf_pkg and the speaker_tone_sample_fifo RTL.
module speaker_tone_sample_fifo_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      stsf_pkg::level_type level;
      stsf_pkg::cnt_type   queued;
      stsf_pkg::fill_type  fill;
   } fifo_reply_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;    // tone_delay[7:0], flip_count[15:8]
   logic        req_tuser   = 1'b0;  // kind
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;           // sample_level[1:0], queued_count[13:2], queue_fill[27:14]
   logic        csr_wr_en   = 1'b0;
   logic [17:0] csr_wr_data = '0;    // out_rate

   fifo_reply_type fifo_reply_q[$];
   int          mismatch_count = 0;
   int          send_idle_pct  = 0;
   int          rsp_stall_pct  = 0;

   // Model of the block: one bit per stored sample, the ring indexes and the rate register.
   bit          model_bits [stsf_pkg::QUEUE_DEPTH];
   int unsigned model_rd   = 0;
   int unsigned model_wr   = 0;
   int unsigned model_fill = 0;
   int unsigned model_rate = stsf_pkg::SR_RESET;

   speaker_tone_sample_fifo i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("speaker_tone_sample_fifo_tb failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic fifo_reply_type predict_fifo_reply(logic kind, logic [7:0] dly,
                                                         logic [7:0] flips);
      fifo_reply_type  r;
      int unsigned     toggle_hz;
      int unsigned     space;
      int unsigned     acc;
      int unsigned     steps;
      int unsigned     n;
      int unsigned     k;
      longint unsigned burst;
      bit              hi;
      r.level  = stsf_pkg::LEVEL_NONE;
      r.queued = '0;
      if (kind == stsf_pkg::KIND_SAMPLE) begin
         if (model_fill != 0) begin
            r.level  = model_bits[model_rd] ? stsf_pkg::LEVEL_HIGH : stsf_pkg::LEVEL_LOW;
            model_rd = (model_rd + 1) % stsf_pkg::QUEUE_DEPTH;
            model_fill--;
         end
      end else begin
         // The toggle rate is the CPU clock over the loop period, two speaker flips per period.
         toggle_hz = stsf_pkg::CPU_CLOCK_HZ / ((19 * int'(dly) + 56) * 2);
         burst     = (longint'(model_rate) * flips) / toggle_hz;
         space     = stsf_pkg::QUEUE_DEPTH - model_fill;
         if (burst > stsf_pkg::BURST_LIMIT) begin
            burst = stsf_pkg::BURST_LIMIT;
         end
         if (burst > space) begin
            burst = space;
         end
         n   = int'(burst);
         acc = 0;
         hi  = 1'b0;
         for (k = 0; k < n; k++) begin
            model_bits[model_wr] = hi;
            model_wr = (model_wr + 1) % stsf_pkg::QUEUE_DEPTH;
            if (model_rate != 0) begin
               acc  += toggle_hz;
               steps = acc / model_rate;
               acc  -= steps * model_rate;
               if (steps[0]) begin
                  hi = !hi;
               end
            end
         end
         model_fill += n;
         r.queued    = stsf_pkg::cnt_type'(n);
      end
      r.fill = stsf_pkg::fill_type'(model_fill);
      return r;
   endfunction

   // Sends one item, with random idle cycles ahead of it, and records its predicted reply.
   task automatic send_item(input logic kind, input logic [7:0] dly, input logic [7:0] flips);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {flips, dly};
      do @(posedge clock); while (!req_tready);
      fifo_reply_q.push_back(predict_fifo_reply(kind, dly, flips));
   endtask

   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      while (fifo_reply_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_out_rate(input int unsigned value);
      wait_for_replies();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= stsf_pkg::sr_type'(value);
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      model_rate = int'(stsf_pkg::sr_type'(value));
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      fifo_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (fifo_reply_q.size() == 0) begin
            report_mismatch("reply transfer with no item outstanding");
         end else begin
            want = fifo_reply_q.pop_front();
            if (rsp_tdata[1:0] !== want.level)
               report_mismatch($sformatf("sample_level got %0d want %0d",
                                         $signed(rsp_tdata[1:0]), $signed(want.level)));
            if (rsp_tdata[13:2] !== want.queued)
               report_mismatch($sformatf("queued_count got %0d want %0d",
                                         rsp_tdata[13:2], want.queued));
            if (rsp_tdata[27:14] !== want.fill)
               report_mismatch($sformatf("queue_fill got %0d want %0d",
                                         rsp_tdata[27:14], want.fill));
         end
      end
   end

   // Pops on an empty FIFO, zero-length and short tones, then pops that return them.
   task automatic test_empty_and_short();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_item(stsf_pkg::KIND_SAMPLE, 8'hFF, 8'hFF);
      send_item(stsf_pkg::KIND_SAMPLE, 8'h00, 8'h00);
      send_item(stsf_pkg::KIND_PLAY, 8'd0, 8'd0);
      send_item(stsf_pkg::KIND_PLAY, 8'd0, 8'd255);
      send_item(stsf_pkg::KIND_PLAY, 8'd255, 8'd1);
      send_item(stsf_pkg::KIND_PLAY, 8'd128, 8'd2);
      repeat (3) send_item(stsf_pkg::KIND_SAMPLE, 8'h55, 8'hAA);
   endtask

   // Output rates at and beyond the usual range: zero and tiny rates push nothing,
   // rates below the toggle rate flip several times per sample.
   task automatic test_rate_extremes();
      int unsigned rates [5] = '{0, 1, 8000, 262143, 192000};
      send_idle_pct = 17;
      rsp_stall_pct = 17;
      foreach (rates[i]) begin
         write_out_rate(rates[i]);
         send_item(stsf_pkg::KIND_PLAY, 8'd0, 8'd255);
         send_item(stsf_pkg::KIND_SAMPLE, 8'hAA, 8'h55);
      end
   endtask

   // Fills the FIFO with capped bursts, hits the full case and wraps the write index,
   // then takes part of the queue back out.
   task automatic test_fill_and_wrap();
      write_out_rate(stsf_pkg::SR_RESET);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      while (model_fill < stsf_pkg::QUEUE_DEPTH) begin
         send_item(stsf_pkg::KIND_PLAY, 8'd255, 8'd255);
      end
      send_item(stsf_pkg::KIND_PLAY, 8'd255, 8'd255);
      repeat (10) send_item(stsf_pkg::KIND_SAMPLE, 8'h00, 8'hFF);
      send_item(stsf_pkg::KIND_PLAY, 8'd255, 8'd255);
      repeat (20) send_item(stsf_pkg::KIND_SAMPLE, 8'($urandom), 8'($urandom));
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct,
                                      input int unsigned rate);
      logic       kind;
      logic [7:0] dly;
      logic [7:0] flips;
      write_out_rate(rate);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         // Halfway through, hold off until every reply is back.
         if (i == count / 2) begin
            wait_for_replies();
         end
         kind  = ($urandom_range(99) < (model_fill > 3000 ? 75 : 45)) ?
                 stsf_pkg::KIND_SAMPLE : stsf_pkg::KIND_PLAY;
         dly   = 8'($urandom);
         flips = ($urandom_range(99) < 85) ? 8'($urandom_range(3)) : 8'($urandom);
         send_item(kind, dly, flips);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_short();
      test_rate_extremes();
      test_fill_and_wrap();
      test_random_traffic(55, 0, 0, $urandom_range(192000, 8000));
      test_random_traffic(55, 77, 0, $urandom_range(192000, 8000));
      test_random_traffic(55, 0, 77, $urandom_range(262143));
      test_random_traffic(55, 17, 17, $urandom_range(192000, 8000));
      wait_for_replies();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("speaker_tone_sample_fifo_tb passed");
      end else begin
         $display("speaker_tone_sample_fifo_tb failed");
      end
      $finish;
   end

endmodule
